### design/lobm_pkg.sv
// Shared types, codes and constants of the limit order book matcher.
`default_nettype none
package lobm_pkg;

  localparam int SIDE_DEPTH_DEF = 32;
  localparam int MAX_FILLS      = 32;
  localparam int FILL_IW        = $clog2(MAX_FILLS);
  localparam int FILL_CW        = $clog2(MAX_FILLS + 1);
  localparam int ID_W           = 64;
  localparam int PX_W           = 32;
  localparam int QTY_W          = 32;
  localparam int CNT_OUT_W      = 7;

  localparam logic [1:0] REQ_MARKET = 2'd0;
  localparam logic [1:0] REQ_LIMIT  = 2'd1;

  localparam logic [2:0] OUT_RESTED    = 3'd0;
  localparam logic [2:0] OUT_FILLED    = 3'd1;
  localparam logic [2:0] OUT_DROPPED   = 3'd2;
  localparam logic [2:0] OUT_CANCELLED = 3'd3;
  localparam logic [2:0] OUT_NOT_FOUND = 3'd4;
  localparam logic [2:0] OUT_FULL      = 3'd5;

  typedef enum logic [1:0] {
    KIND_MARKET,
    KIND_LIMIT,
    KIND_CANCEL
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic               is_sell;
    logic [ID_W-1:0]    id;
    logic [PX_W-1:0]    price;
    logic [QTY_W-1:0]   qty;
  } item_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_FILL,
    OP_CANCEL,
    OP_INSERT
  } book_op_t;

  typedef struct packed {
    book_op_t           op;
    logic [ID_W-1:0]    id;
    logic [PX_W-1:0]    price;
    logic [QTY_W-1:0]   qty;
  } book_cmd_t;

  typedef struct packed {
    logic               head_valid;
    logic [ID_W-1:0]    head_id;
    logic [PX_W-1:0]    head_price;
    logic [QTY_W-1:0]   head_rem;
    logic               found;
    logic               full;
  } book_stat_t;

  typedef struct packed {
    logic [ID_W-1:0]    buy_id;
    logic [ID_W-1:0]    sell_id;
    logic [PX_W-1:0]    price;
    logic [QTY_W-1:0]   qty;
  } trade_t;

endpackage
`default_nettype wire

### design/lobm_if.sv
// Request and result channel interfaces.
`default_nettype none
interface lobm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic        side;
  logic [63:0] oid;
  logic [31:0] price;
  logic [31:0] quantity;
  modport source (output valid, req_type, side, oid, price, quantity, input ready);
  modport sink   (input valid, req_type, side, oid, price, quantity, output ready);
endinterface

interface lobm_res_if;
  logic        valid;
  logic        ready;
  logic        is_trade;
  logic [63:0] buy_id;
  logic [63:0] sell_id;
  logic [31:0] trade_price;
  logic [31:0] trade_qty;
  logic        last;
  logic [2:0]  outcome;
  logic [31:0] top_bid;
  logic [31:0] top_ask;
  logic [31:0] spread;
  logic [6:0]  resting_count;
  modport source (output valid, is_trade, buy_id, sell_id, trade_price, trade_qty, last,
                  outcome, top_bid, top_ask, spread, resting_count, input ready);
  modport sink   (input valid, is_trade, buy_id, sell_id, trade_price, trade_qty, last,
                  outcome, top_bid, top_ask, spread, resting_count, output ready);
endinterface
`default_nettype wire

### design/lobm_front.sv
// Front end: takes request words, classifies them, queues them for the engine.
`default_nettype none
module lobm_front (
  input  wire logic          clk,
  input  wire logic          rst,
  lobm_req_if.sink           order,
  output lobm_pkg::item_t    head,
  output logic               head_valid,
  input  wire logic          pop
);
  lobm_pkg::item_t q [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fill;
  lobm_pkg::item_t cls;
  logic            push;

  always_comb begin
    cls.is_sell = order.side;
    cls.id      = order.oid;
    cls.price   = order.price;
    cls.qty     = order.quantity;
    case (order.req_type)
      lobm_pkg::REQ_MARKET: cls.kind = lobm_pkg::KIND_MARKET;
      lobm_pkg::REQ_LIMIT:  cls.kind = lobm_pkg::KIND_LIMIT;
      default:              cls.kind = lobm_pkg::KIND_CANCEL; // both cancel codes
    endcase
  end

  assign order.ready = (fill != 2'd2);
  assign push        = order.valid && order.ready;
  assign head_valid  = (fill != 2'd0);
  assign head        = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop && head_valid) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop && head_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cls;
  end
endmodule
`default_nettype wire

### design/lobm_book.sv
// One side of the book: a row of sorted cells, best entry in cell 0.
`default_nettype none
module lobm_book #(
  parameter int DEPTH  = lobm_pkg::SIDE_DEPTH_DEF,
  parameter bit IS_BID = 1'b1,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lobm_pkg::book_cmd_t cmd,
  output lobm_pkg::book_stat_t   stat,
  output logic [CW-1:0]          count
);
  logic                          vld     [DEPTH];
  logic [lobm_pkg::ID_W-1:0]     ids     [DEPTH];
  logic [lobm_pkg::PX_W-1:0]     prs     [DEPTH];
  logic [lobm_pkg::QTY_W-1:0]    rems    [DEPTH];
  logic                          vld_next[DEPTH];
  logic [lobm_pkg::ID_W-1:0]     ids_next[DEPTH];
  logic [lobm_pkg::PX_W-1:0]     prs_next[DEPTH];
  logic [lobm_pkg::QTY_W-1:0]    rems_next[DEPTH];
  logic [DEPTH-1:0]              match;
  logic [DEPTH-1:0]              after;
  logic [DEPTH-1:0]              ahead;   // entries staying in front of an insert
  logic [lobm_pkg::QTY_W-1:0]    head_left;
  logic                          full;
  logic [CW-1:0]                 count_next;

  assign full      = (count == CW'(DEPTH));
  assign head_left = rems[0] - cmd.qty;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = vld[i] && (ids[i] == cmd.id);
      ahead[i] = vld[i] && (IS_BID ? (prs[i] >= cmd.price) : (prs[i] <= cmd.price));
    end
    after[0] = match[0];
    for (int i = 1; i < DEPTH; i++) after[i] = after[i-1] | match[i];
  end

  assign stat.head_valid = vld[0];
  assign stat.head_id    = ids[0];
  assign stat.head_price = prs[0];
  assign stat.head_rem   = rems[0];
  assign stat.found      = |match;
  assign stat.full       = full;

  always_comb begin
    count_next = count;
    for (int i = 0; i < DEPTH; i++) begin
      vld_next[i]  = vld[i];
      ids_next[i]  = ids[i];
      prs_next[i]  = prs[i];
      rems_next[i] = rems[i];
    end
    case (cmd.op)
      lobm_pkg::OP_FILL: begin
        if (head_left == '0) begin
          count_next = count - CW'(1);
          for (int i = 0; i < DEPTH - 1; i++) begin
            vld_next[i]  = vld[i+1];
            ids_next[i]  = ids[i+1];
            prs_next[i]  = prs[i+1];
            rems_next[i] = rems[i+1];
          end
          vld_next[DEPTH-1] = 1'b0;
        end else begin
          rems_next[0] = head_left;
        end
      end
      lobm_pkg::OP_CANCEL: begin
        if (|match) begin
          count_next = count - CW'(1);
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (after[i]) begin
              vld_next[i]  = vld[i+1];
              ids_next[i]  = ids[i+1];
              prs_next[i]  = prs[i+1];
              rems_next[i] = rems[i+1];
            end
          end
          vld_next[DEPTH-1] = 1'b0;
        end
      end
      lobm_pkg::OP_INSERT: begin
        if (!full) begin
          count_next = count + CW'(1);
          for (int i = 0; i < DEPTH; i++) begin
            if (!ahead[i]) begin
              if (i == 0 || ahead[(i == 0) ? 0 : i-1]) begin
                vld_next[i]  = 1'b1;
                ids_next[i]  = cmd.id;
                prs_next[i]  = cmd.price;
                rems_next[i] = cmd.qty;
              end else begin
                vld_next[i]  = vld[i-1];
                ids_next[i]  = ids[i-1];
                prs_next[i]  = prs[i-1];
                rems_next[i] = rems[i-1];
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int i = 0; i < DEPTH; i++) vld[i] <= 1'b0;
    end else begin
      count <= count_next;
      for (int i = 0; i < DEPTH; i++) vld[i] <= vld_next[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      ids[i]  <= ids_next[i];
      prs[i]  <= prs_next[i];
      rems[i] <= rems_next[i];
    end
  end
endmodule
`default_nettype wire

### design/lobm_engine.sv
// Back end: matching sequencer, trade buffer and result output register.
`default_nettype none
module lobm_engine #(
  parameter int DEPTH = lobm_pkg::SIDE_DEPTH_DEF,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire lobm_pkg::item_t      head,
  input  wire logic                 head_valid,
  output logic                      pop,
  input  wire lobm_pkg::book_stat_t bid_stat,
  input  wire lobm_pkg::book_stat_t ask_stat,
  input  wire logic [CW-1:0]        bid_count,
  input  wire logic [CW-1:0]        ask_count,
  output lobm_pkg::book_cmd_t       bid_cmd,
  output lobm_pkg::book_cmd_t       ask_cmd,
  lobm_res_if.source                result
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SUMM = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                         state;
  lobm_pkg::item_t                cur;
  logic [lobm_pkg::FILL_CW-1:0]   fills;
  logic [lobm_pkg::FILL_CW-1:0]   emit_idx;
  logic [lobm_pkg::FILL_CW-1:0]   n_res;
  logic [2:0]                     outcome;
  logic [31:0]                    bb;
  logic [31:0]                    ba;
  logic [31:0]                    sp;
  logic [6:0]                     rcount;
  lobm_pkg::trade_t               tbuf [lobm_pkg::MAX_FILLS];

  lobm_pkg::book_stat_t           opp;
  logic                           is_limit;
  logic                           stop_px;
  logic                           can_fill;
  logic [lobm_pkg::QTY_W-1:0]     fqty;
  lobm_pkg::trade_t               tnew;
  logic                           own_full;
  logic [31:0]                    bb_now;
  logic [31:0]                    ba_now;
  logic [CW:0]                    cnt_sum;
  logic                           load;
  lobm_pkg::trade_t               trd;

  assign opp      = cur.is_sell ? bid_stat : ask_stat;
  assign own_full = cur.is_sell ? ask_stat.full : bid_stat.full;
  assign is_limit = (cur.kind == lobm_pkg::KIND_LIMIT);
  assign stop_px  = is_limit && (cur.is_sell ? (cur.price > opp.head_price)
                                             : (cur.price < opp.head_price));
  assign can_fill = opp.head_valid && (cur.qty != '0) &&
                    (fills != lobm_pkg::FILL_CW'(lobm_pkg::MAX_FILLS)) && !stop_px;
  assign fqty     = (cur.qty < opp.head_rem) ? cur.qty : opp.head_rem;

  always_comb begin
    tnew.buy_id  = cur.is_sell ? opp.head_id : cur.id;
    tnew.sell_id = cur.is_sell ? cur.id : opp.head_id;
    tnew.price   = opp.head_price;
    tnew.qty     = fqty;
  end

  // book commands for this cycle
  always_comb begin
    bid_cmd.op    = lobm_pkg::OP_NONE;
    ask_cmd.op    = lobm_pkg::OP_NONE;
    bid_cmd.id    = cur.id;
    ask_cmd.id    = cur.id;
    bid_cmd.price = cur.price;
    ask_cmd.price = cur.price;
    bid_cmd.qty   = can_fill ? fqty : cur.qty;
    ask_cmd.qty   = can_fill ? fqty : cur.qty;
    if (state == S_EXEC) begin
      if (cur.kind == lobm_pkg::KIND_CANCEL) begin
        if (bid_stat.found) bid_cmd.op = lobm_pkg::OP_CANCEL;
        else                ask_cmd.op = lobm_pkg::OP_CANCEL;
      end else if (can_fill) begin
        if (cur.is_sell) bid_cmd.op = lobm_pkg::OP_FILL;
        else             ask_cmd.op = lobm_pkg::OP_FILL;
      end else if (cur.qty != '0 && is_limit && !own_full) begin
        if (cur.is_sell) ask_cmd.op = lobm_pkg::OP_INSERT;
        else             bid_cmd.op = lobm_pkg::OP_INSERT;
      end
    end
  end

  assign pop     = (state == S_IDLE) && head_valid;
  assign bb_now  = bid_stat.head_valid ? bid_stat.head_price : '0;
  assign ba_now  = ask_stat.head_valid ? ask_stat.head_price : '0;
  assign cnt_sum = {1'b0, bid_count} + {1'b0, ask_count};
  assign load    = (state == S_EMIT) && (!result.valid || result.ready);
  assign trd     = tbuf[emit_idx[lobm_pkg::FILL_IW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result.valid <= 1'b0;
    end else begin
      if (load) result.valid <= 1'b1;
      else if (result.ready) result.valid <= 1'b0;
      case (state)
        S_IDLE: if (head_valid) state <= S_EXEC;
        S_EXEC: if (cur.kind == lobm_pkg::KIND_CANCEL || !can_fill) state <= S_SUMM;
        S_SUMM: state <= S_EMIT;
        S_EMIT: begin
          if (load && (emit_idx + lobm_pkg::FILL_CW'(1) == n_res)) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur   <= head;
        fills <= '0;
      end
      S_EXEC: begin
        if (cur.kind == lobm_pkg::KIND_CANCEL) begin
          outcome <= (bid_stat.found || ask_stat.found) ? lobm_pkg::OUT_CANCELLED
                                                        : lobm_pkg::OUT_NOT_FOUND;
        end else if (can_fill) begin
          tbuf[fills[lobm_pkg::FILL_IW-1:0]] <= tnew;
          fills   <= fills + lobm_pkg::FILL_CW'(1);
          cur.qty <= cur.qty - fqty;
        end else if (cur.qty == '0) begin
          outcome <= lobm_pkg::OUT_FILLED;
        end else if (!is_limit) begin
          outcome <= lobm_pkg::OUT_DROPPED;
        end else begin
          outcome <= own_full ? lobm_pkg::OUT_FULL : lobm_pkg::OUT_RESTED;
        end
      end
      S_SUMM: begin
        bb       <= bb_now;
        ba       <= ba_now;
        sp       <= (bb_now == '0 || ba_now == '0 || ba_now < bb_now) ? '0 : ba_now - bb_now;
        rcount   <= lobm_pkg::CNT_OUT_W'(cnt_sum);
        n_res    <= (fills == '0) ? lobm_pkg::FILL_CW'(1) : fills;
        emit_idx <= '0;
      end
      S_EMIT: begin
        if (load) begin
          emit_idx             <= emit_idx + lobm_pkg::FILL_CW'(1);
          result.is_trade      <= (fills != '0);
          result.buy_id        <= (fills != '0) ? trd.buy_id : '0;
          result.sell_id       <= (fills != '0) ? trd.sell_id : '0;
          result.trade_price   <= (fills != '0) ? trd.price : '0;
          result.trade_qty     <= (fills != '0) ? trd.qty : '0;
          result.last          <= (emit_idx + lobm_pkg::FILL_CW'(1) == n_res);
          result.outcome       <= outcome;
          result.top_bid       <= bb;
          result.top_ask       <= ba;
          result.spread        <= sp;
          result.resting_count <= rcount;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### design/limit_order_book_matcher.sv
// Top level of the price-time priority limit order book matcher.
`default_nettype none
// Keeps a bid book and an ask book of SIDE_DEPTH orders each, sorted by price and
// then arrival, and matches market, limit and cancel requests against them.
// Every request word yields one or more result words: one per fill (up to 32),
// or a single non-trade word; all words of one request carry the same outcome,
// best bid, best ask, spread and resting count, so trades are buffered and
// released once the request is finished. The front end queues up to two
// requests so the order channel keeps flowing while the engine works.
// Steps per request: fetch, then one fill per cycle, then finish (rest, drop or
// cancel), then summarise, then one result word per cycle at the output register
// while the receiver keeps ready high.
// The fill walk is bound by the single head cell of the opposite book.
// No clearing pass is needed after reset.
module limit_order_book_matcher #(
  parameter int SIDE_DEPTH = lobm_pkg::SIDE_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  lobm_req_if.sink    order,
  lobm_res_if.source  result
);
  localparam int CW = $clog2(SIDE_DEPTH + 1);

  lobm_pkg::item_t      head;
  logic                 head_valid;
  logic                 pop;
  lobm_pkg::book_cmd_t  bid_cmd;
  lobm_pkg::book_cmd_t  ask_cmd;
  lobm_pkg::book_stat_t bid_stat;
  lobm_pkg::book_stat_t ask_stat;
  logic [CW-1:0]        bid_count;
  logic [CW-1:0]        ask_count;

  // classify and queue incoming words
  lobm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .order      (order),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  // bids: highest price first
  lobm_book #(.DEPTH(SIDE_DEPTH), .IS_BID(1'b1)) u_bids (
    .clk   (clk),
    .rst   (rst),
    .cmd   (bid_cmd),
    .stat  (bid_stat),
    .count (bid_count)
  );

  // asks: lowest price first
  lobm_book #(.DEPTH(SIDE_DEPTH), .IS_BID(1'b0)) u_asks (
    .clk   (clk),
    .rst   (rst),
    .cmd   (ask_cmd),
    .stat  (ask_stat),
    .count (ask_count)
  );

  // matching sequencer and result register
  lobm_engine #(.DEPTH(SIDE_DEPTH)) u_engine (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .bid_stat   (bid_stat),
    .ask_stat   (ask_stat),
    .bid_count  (bid_count),
    .ask_count  (ask_count),
    .bid_cmd    (bid_cmd),
    .ask_cmd    (ask_cmd),
    .result     (result)
  );
endmodule
`default_nettype wire
